### rtl/core/kcm_pkg.sv
// ----------------------------------------------------------------------------
// kcm_pkg: shared types and constants for key change to midi notes
// key count, register indexes, job word between front and back, bit search
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kcm_pkg;

  localparam int KEYS        = 32;  // keys taken into account, at most 32
  localparam int MAP_W       = 32;  // width of one key bitmap
  localparam int IDX_W       = 5;   // index of one bitmap bit
  localparam int CNT_W       = 6;   // active key count
  localparam int NOTE_W      = 8;
  localparam int BASE_W      = 7;
  localparam int VEL_W       = 7;
  localparam int CFG_DATA_W  = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [VEL_W-1:0] VEL_ON  = 7'd127;
  localparam logic [VEL_W-1:0] VEL_OFF = 7'd0;

  // effective key limit, min(KEYS, 32)
  localparam logic [CNT_W-1:0] KEY_LIMIT = CNT_W'((KEYS < MAP_W) ? KEYS : MAP_W);

  typedef enum logic [0:0] {
    REG_BASE_NOTE   = 1'b0,
    REG_ACTIVE_KEYS = 1'b1
  } reg_index_t;

  // one classified bitmap change waiting for serialisation
  typedef struct packed {
    logic [MAP_W-1:0] pressed;
    logic [MAP_W-1:0] released;
  } job_t;

  // index of the lowest set bit, zero for an empty vector
  function automatic logic [IDX_W-1:0] low_index(input logic [MAP_W-1:0] vec);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

### rtl/core/kcm_front.sv
// ----------------------------------------------------------------------------
// kcm_front: bitmap intake and change classification
// keeps the previous bitmap and turns each new one into release and press sets
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kcm_front
  import kcm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [MAP_W-1:0]      key_bits,
  input  wire logic [CNT_W-1:0]      active_keys,
  input  wire logic                  queue_full,
  output      logic                  push,
  output      job_t                  push_job
);

  logic [MAP_W-1:0] prev_keys;
  logic [CNT_W-1:0] n_eff;
  logic [MAP_W-1:0] mask;
  logic             take;

  assign in_ready = !queue_full;
  assign take     = in_valid && in_ready;

  always_comb begin
    n_eff = (active_keys > KEY_LIMIT) ? KEY_LIMIT : active_keys;
    if (n_eff >= CNT_W'(MAP_W)) begin
      mask = '1;
    end else begin
      mask = (MAP_W'(1) << n_eff[IDX_W-1:0]) - MAP_W'(1);
    end
    push_job.released = prev_keys & ~key_bits & mask;
    push_job.pressed  = key_bits & ~prev_keys & mask;
  end

  // only a bitmap with messages goes to the queue
  assign push = take && ((push_job.released | push_job.pressed) != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_keys <= '0;
    end else if (take) begin
      prev_keys <= key_bits;
    end
  end

endmodule

`default_nettype wire

### rtl/core/kcm_queue.sv
// ----------------------------------------------------------------------------
// kcm_queue: short job queue
// decouples the classifier from the message serialiser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kcm_queue
  import kcm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output      logic full,
  output      logic nonempty,
  output      job_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  job_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  assign full     = (fill == FILL_W'(QUEUE_DEPTH));
  assign nonempty = (fill != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/kcm_back.sv
// ----------------------------------------------------------------------------
// kcm_back: message serialiser
// walks releases then presses lowest key first; unless the output stalls, one message per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kcm_back
  import kcm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              job_valid,
  input  wire job_t              job,
  output      logic              pop,
  input  wire logic [BASE_W-1:0] base_note,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic              note_on,
  output      logic [NOTE_W-1:0] note_number,
  output      logic [VEL_W-1:0]  velocity,
  output      logic              last
);

  logic [MAP_W-1:0] released;
  logic [MAP_W-1:0] pressed;
  logic [MAP_W-1:0] released_next;
  logic [MAP_W-1:0] pressed_next;
  logic [MAP_W-1:0] vec;
  logic [IDX_W-1:0] idx;
  logic             busy;
  logic             from_rel;
  logic             emit;

  assign busy     = (released != '0) || (pressed != '0);
  assign pop      = !busy && job_valid;
  assign emit     = busy && (!out_valid || out_ready);
  assign from_rel = (released != '0);
  assign vec      = from_rel ? released : pressed;
  assign idx      = low_index(vec);

  always_comb begin
    released_next = released;
    pressed_next  = pressed;
    if (from_rel) begin
      released_next[idx] = 1'b0;
    end else begin
      pressed_next[idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      released  <= '0;
      pressed   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        released <= job.released;
        pressed  <= job.pressed;
      end else if (emit) begin
        released <= released_next;
        pressed  <= pressed_next;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (emit) begin
      note_on     <= !from_rel;
      note_number <= NOTE_W'(idx) + NOTE_W'(1) + NOTE_W'(base_note);
      velocity    <= from_rel ? VEL_OFF : VEL_ON;
      last        <= (released_next == '0) && (pressed_next == '0);
    end
  end

endmodule

`default_nettype wire

### rtl/core/key_change_to_midi_notes.sv
// ----------------------------------------------------------------------------
// key_change_to_midi_notes: key bitmap changes to midi note messages
// compares each key scan with the previous one and streams note-off / note-on
// ----------------------------------------------------------------------------
// Each input word is a full key bitmap (bit i is key i+1). The block compares
// it with the previous bitmap (all zero after reset) over the low active_keys
// bits and sends one output word per changed key: first every release as a
// note-off with velocity 0, then every press as a note-on with velocity 127,
// each group in ascending key order, with tlast on the final message of the
// bitmap. Channel 0 is implied. A bitmap with no change in the active keys
// gives no output word, but is still stored. Flow: the intake takes one
// bitmap per cycle into a two-entry job queue; the serialiser loads a job
// only when it holds no messages and then sends them one after another,
// advancing while the output is not stalled, each found by the single lowest
// bit search in the serialiser. The input stalls only when the queue is full.
// Registers (write while idle): index 0 base_note (7 bits, reset 0), index 1
// active_keys (6 bits, reset 32, values above 32 act as 32).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module key_change_to_midi_notes
  import kcm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // bitmap input: tdata = key_bits[31:0]
  input  wire logic                  s_tvalid,
  output      logic                  s_tready,
  input  wire logic [MAP_W-1:0]      s_tdata,
  // message output: tdata = note_number[7:0], velocity[14:8], zero pad [15]
  output      logic                  m_tvalid,
  input  wire logic                  m_tready,
  output      logic [15:0]           m_tdata,
  // tuser = note_on[0]
  output      logic [0:0]            m_tuser,
  output      logic                  m_tlast,
  // register write channel
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [0:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [BASE_W-1:0] base_note;
  logic [CNT_W-1:0]  active_keys;

  logic              push;
  job_t              push_job;
  logic              queue_full;
  logic              queue_nonempty;
  job_t              head;
  logic              pop;

  logic              note_on;
  logic [NOTE_W-1:0] note_number;
  logic [VEL_W-1:0]  velocity;

  // registers always take a write at once
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_note   <= '0;
      active_keys <= CNT_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_BASE_NOTE:   base_note   <= cfg_data[BASE_W-1:0];
        REG_ACTIVE_KEYS: active_keys <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // front: intake and classification against the stored bitmap
  kcm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .key_bits    (s_tdata),
    .active_keys (active_keys),
    .queue_full  (queue_full),
    .push        (push),
    .push_job    (push_job)
  );

  // jobs waiting for the serialiser
  kcm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (queue_full),
    .nonempty (queue_nonempty),
    .head     (head)
  );

  // back: one message per cycle into the output register while the output is not stalled
  kcm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (queue_nonempty),
    .job         (head),
    .pop         (pop),
    .base_note   (base_note),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .note_on     (note_on),
    .note_number (note_number),
    .velocity    (velocity),
    .last        (m_tlast)
  );

  assign m_tdata = {1'b0, velocity, note_number};
  assign m_tuser = note_on;

endmodule

`default_nettype wire

### rtl/core/kcm_checker.sv
// ----------------------------------------------------------------------------
// kcm_checker: port level checks for key_change_to_midi_notes
// output hold under stall, reset quiet, zero pad bit and velocity tied to message kind
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kcm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [0:0]  m_tuser,
  input wire logic        m_tlast
);

  // no message straight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid right after reset");

  // note-on carries full velocity, note-off zero
  a_velocity: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser[0] && m_tdata[14:8] == 7'd127) ||
                  (!m_tuser[0] && m_tdata[14:8] == 7'd0)))
    else $error("velocity does not match message kind");

  // pad bit stays zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[15])
    else $error("pad bit set");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled output word changed");

endmodule

bind key_change_to_midi_notes kcm_checker u_kcm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
